// File: src/sm3_pkg.sv
// sm3 core package: constants, sequencer states and round helper functions
package sm3_pkg;

	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;

	localparam int unsigned WIN_DEPTH  = 16;
	localparam int unsigned CHAIN_WORDS = 8;
	localparam int unsigned ROUNDS     = 64;

	localparam logic [31:0] SM3_IV [CHAIN_WORDS] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} sm3_state_t;

	typedef logic [31:0] word_t;

	// rotate left by a constant amount
	function automatic word_t rotl32(input word_t x, input int unsigned n);
		word_t r;
		r = (x << (n % 32)) | (x >> ((32 - (n % 32)) % 32));
		return r;
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ rotl32(x, 9) ^ rotl32(x, 17);
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ rotl32(x, 15) ^ rotl32(x, 23);
	endfunction

endpackage

// File: src/sm3_in_if.sv
// message word channel: valid/ready with one padded message word per beat
interface sm3_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] msg_word;
	logic        last_word;

	modport source (output valid, output msg_word, output last_word, input ready);
	modport sink (input valid, input msg_word, input last_word, output ready);
endinterface

// File: src/sm3_out_if.sv
// digest channel: valid/ready with one digest word per beat
interface sm3_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        digest_last;

	modport source (output valid, output digest_word, output digest_last, input ready);
	modport sink (input valid, input digest_word, input digest_last, output ready);
endinterface

// File: src/sm3_hash_core_unit.sv
// sm3 hash core top level: word loader, expansion window, round unit and digest output
//
// The core hashes an already padded message given as 32-bit big-endian words,
// 16 words to a block. Words are taken one per beat while the core is loading;
// the 16th word starts compression, which runs one round per cycle on a single
// shared round unit with the message expansion done on the fly in a 16-word
// sliding window, and then folds the result into the chaining value. Input
// ready is low during the rounds and the fold, so no word of the next block
// is taken until the current block is folded. When the completing word
// carries last_word, the eight digest words (A first, H last with digest_last
// set) leave as eight beats before loading resumes, and the chaining value
// returns to the initial vector. A flag on a word that does not complete a
// block is ignored.
module sm3_hash_core_unit
	import sm3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sm3_in_if.sink    msg_in,
	sm3_out_if.source dig_out
);

	sm3_state_t state_q, state_d;

	word_t       win_q   [WIN_DEPTH];
	word_t       chain_q [CHAIN_WORDS];
	word_t       work_q  [CHAIN_WORDS];
	word_t       dig_q   [CHAIN_WORDS];
	word_t       t_q;
	logic [3:0]  wcnt_q;
	logic [5:0]  rnd_q;
	logic [2:0]  dcnt_q;
	logic        last_q;

	logic  in_beat, out_beat, block_done;
	word_t a12, ss1, ss2, ff, gg, tt1, tt2, w_next, t_next;

	assign in_beat    = msg_in.valid && msg_in.ready;
	assign out_beat   = dig_out.valid && dig_out.ready;
	assign block_done = in_beat && (wcnt_q == 4'(WIN_DEPTH - 1));

	// sequencer next state and handshake
	always_comb begin
		state_d         = state_q;
		msg_in.ready    = 1'b0;
		dig_out.valid   = 1'b0;
		case (state_q)
			ST_LOAD: begin
				msg_in.ready = 1'b1;
				if (block_done) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == 6'(ROUNDS - 1)) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				state_d = last_q ? ST_EMIT : ST_LOAD;
			end
			ST_EMIT: begin
				dig_out.valid = 1'b1;
				if (out_beat && dcnt_q == 3'(CHAIN_WORDS - 1)) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign dig_out.digest_word = dig_q[0];
	assign dig_out.digest_last = (dcnt_q == 3'(CHAIN_WORDS - 1));

	// shared round unit and expansion of the next window word
	always_comb begin
		a12 = rotl32(work_q[0], 12);
		ss1 = rotl32(a12 + work_q[4] + t_q, 7);
		ss2 = ss1 ^ a12;
		if (rnd_q[5:4] == 2'b00) begin
			ff = work_q[0] ^ work_q[1] ^ work_q[2];
			gg = work_q[4] ^ work_q[5] ^ work_q[6];
		end else begin
			ff = (work_q[0] & work_q[1]) | (work_q[0] & work_q[2]) | (work_q[1] & work_q[2]);
			gg = (work_q[4] & work_q[5]) | (~work_q[4] & work_q[6]);
		end
		tt1    = ff + work_q[3] + ss2 + (win_q[0] ^ win_q[4]);
		tt2    = gg + work_q[7] + ss1 + win_q[0];
		w_next = perm1(win_q[0] ^ win_q[7] ^ rotl32(win_q[13], 15))
			^ rotl32(win_q[3], 7) ^ win_q[10];
		// round constant: rotated by one each round, swapped at round 16
		if (rnd_q == 6'd15) begin
			t_next = rotl32(T_HIGH, 16);
		end else begin
			t_next = rotl32(t_q, 1);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			rnd_q  <= '0;
			dcnt_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (in_beat) begin
				wcnt_q <= wcnt_q + 4'd1;
			end
			if (block_done) begin
				last_q <= msg_in.last_word;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (out_beat) begin
				dcnt_q <= dcnt_q + 3'd1;
			end
		end
	end

	// chaining value, reset to the initial vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= SM3_IV[i];
			end
		end else if (state_q == ST_FOLD) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= last_q ? SM3_IV[i] : (chain_q[i] ^ work_q[i]);
			end
		end
	end

	// message window, working registers, round constant and digest shift line
	always_ff @(posedge clk) begin
		if (in_beat || state_q == ST_ROUND) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WIN_DEPTH - 1] <= in_beat ? msg_in.msg_word : w_next;
		end

		if (block_done) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				work_q[i] <= chain_q[i];
			end
			t_q <= T_LOW;
		end else if (state_q == ST_ROUND) begin
			work_q[0] <= tt1;
			work_q[1] <= work_q[0];
			work_q[2] <= rotl32(work_q[1], 9);
			work_q[3] <= work_q[2];
			work_q[4] <= perm0(tt2);
			work_q[5] <= work_q[4];
			work_q[6] <= rotl32(work_q[5], 19);
			work_q[7] <= work_q[6];
			t_q       <= t_next;
		end

		if (state_q == ST_FOLD) begin
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				dig_q[i] <= chain_q[i] ^ work_q[i];
			end
		end else if (out_beat) begin
			for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
			dig_q[CHAIN_WORDS - 1] <= dig_q[0];
		end
	end

endmodule
